// File: hdl/pafk_pkg.sv
package pafk_pkg;

  localparam int ANGLE_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int MAX_STAGES        = 24;

  // Position and datapath widths.
  localparam int POS_W  = 20;
  localparam int LEN_W  = 16;
  localparam int HEAD_W = 16;
  localparam int CFG_W  = 20;
  localparam int PHASE_W = 32;
  // CORDIC x/y in Q30 with growth headroom.
  localparam int XY_W   = 34;
  // Accumulators in Q38: base<<30 plus four products.
  localparam int ACC_W  = 56;

  localparam logic signed [XY_W-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [POS_W-1:0] POS_MAX = 20'sd524287;
  localparam logic signed [POS_W-1:0] POS_MIN = -20'sd524288;

  // Configuration register indexes.
  localparam logic [2:0] REG_BASE_X   = 3'd0;
  localparam logic [2:0] REG_BASE_Y   = 3'd1;
  localparam logic [2:0] REG_BASE_HD  = 3'd2;
  localparam logic [2:0] REG_LEN_ONE  = 3'd3;
  localparam logic [2:0] REG_LEN_TWO  = 3'd4;
  localparam logic [2:0] REG_LEN_THR  = 3'd5;
  localparam logic [2:0] REG_LEN_FOUR = 3'd6;

  // Arctangent of 2^-i in 2^-32 turn units.
  function automatic logic signed [PHASE_W:0] atan_turn(input int i);
    logic signed [PHASE_W:0] r;
    unique case (i)
      0: r = 33'sd536870912;   1: r = 33'sd316933406;  2: r = 33'sd167458907;
      3: r = 33'sd85004756;    4: r = 33'sd42667331;   5: r = 33'sd21354465;
      6: r = 33'sd10679838;    7: r = 33'sd5340245;    8: r = 33'sd2670163;
      9: r = 33'sd1335087;     10: r = 33'sd667544;    11: r = 33'sd333772;
      12: r = 33'sd166886;     13: r = 33'sd83443;     14: r = 33'sd41722;
      15: r = 33'sd20861;      16: r = 33'sd10430;     17: r = 33'sd5215;
      18: r = 33'sd2608;       19: r = 33'sd1304;      20: r = 33'sd652;
      21: r = 33'sd326;        22: r = 33'sd163;       23: r = 33'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/pafk_cordic.sv
// Unrolled rotation-mode CORDIC, one register stage per iteration. Gives cosine
// and sine in Q30 of a heading in binary angle units. The pipeline advances
// when en is high.
module pafk_cordic #(
  parameter int ANGLE_BITS    = pafk_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = pafk_pkg::CORDIC_STAGES_DEF
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic [pafk_pkg::HEAD_W-1:0]        heading,
  output logic signed [pafk_pkg::XY_W-1:0]   cos_out,
  output logic signed [pafk_pkg::XY_W-1:0]   sin_out
);

  localparam int XW = pafk_pkg::XY_W;
  localparam int ZW = pafk_pkg::PHASE_W + 1;
  localparam int NS = (CORDIC_STAGES < pafk_pkg::MAX_STAGES) ? CORDIC_STAGES
                                                              : pafk_pkg::MAX_STAGES;

  logic signed [XW-1:0] xs [NS+1];
  logic signed [XW-1:0] ys [NS+1];
  logic signed [ZW-1:0] zs [NS+1];
  logic                 fl [NS+1];

  logic [pafk_pkg::PHASE_W-1:0] phase;
  logic [pafk_pkg::PHASE_W-1:0] quarter;
  logic                         fold;

  // Phase setup and half-plane fold at the input register.
  always_comb begin
    phase   = {heading, 16'd0} &
              ({pafk_pkg::PHASE_W{1'b1}} << (pafk_pkg::PHASE_W - ANGLE_BITS));
    quarter = phase + 32'h4000_0000;
    fold    = quarter[pafk_pkg::PHASE_W-1];
    if (fold) begin
      phase = phase - 32'h8000_0000;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= pafk_pkg::GAIN_Q30;
      ys[0] <= '0;
      zs[0] <= {phase[pafk_pkg::PHASE_W-1], phase};
      fl[0] <= fold;
    end
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < NS; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zs[i][ZW-1]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - pafk_pkg::atan_turn(i);
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + pafk_pkg::atan_turn(i);
        end
        fl[i+1] <= fl[i];
      end
    end
  end

  // Undo the fold on the way out.
  always_ff @(posedge clk) begin
    if (en) begin
      cos_out <= fl[NS] ? -xs[NS] : xs[NS];
      sin_out <= fl[NS] ? -ys[NS] : ys[NS];
    end
  end

endmodule

// File: hdl/planar_arm_forward_kinematics.sv
// Forward kinematics of a four-link planar arm. Each word of four joint angles
// (binary angle units, 65536 per turn) yields one word with the four link-end
// positions in signed Q.8 and a flag that is set when any position saturated.
// One word is accepted every cycle while the pipeline is not frozen. The pipeline is one
// heading stage, CORDIC_STAGES + 2 CORDIC stages (CORDIC_STAGES capped at MAX_STAGES), one multiply
// stage, two accumulate stages and one round-and-saturate stage that ends in the output
// register. The whole pipeline freezes while the output is stalled and full.
module planar_arm_forward_kinematics #(
  parameter int ANGLE_BITS    = pafk_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = pafk_pkg::CORDIC_STAGES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [2:0]                       cfg_index,
  input  logic [pafk_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [15:0]               joint_one_angle,
  input  logic signed [15:0]               joint_two_angle,
  input  logic signed [15:0]               joint_three_angle,
  input  logic signed [15:0]               joint_four_angle,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [19:0]               end_one_x,
  output logic signed [19:0]               end_one_y,
  output logic signed [19:0]               end_two_x,
  output logic signed [19:0]               end_two_y,
  output logic signed [19:0]               end_three_x,
  output logic signed [19:0]               end_three_y,
  output logic signed [19:0]               tip_x,
  output logic signed [19:0]               tip_y,
  output logic                             clipped
);

  localparam int XW  = pafk_pkg::XY_W;
  localparam int AW  = pafk_pkg::ACC_W;
  localparam int PW  = pafk_pkg::POS_W;
  localparam int NS  = (CORDIC_STAGES < pafk_pkg::MAX_STAGES) ? CORDIC_STAGES
                                                               : pafk_pkg::MAX_STAGES;
  // Heading stage, CORDIC, multiply, two adds, round.
  localparam int DEPTH = NS + 7;

  logic signed [PW-1:0] base_x;
  logic signed [PW-1:0] base_y;
  logic [15:0]          base_heading;
  logic [15:0]          link_len [4];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_x       <= '0;
      base_y       <= '0;
      base_heading <= '0;
      for (int k = 0; k < 4; k++) link_len[k] <= 16'd512;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pafk_pkg::REG_BASE_X:   base_x       <= cfg_data;
        pafk_pkg::REG_BASE_Y:   base_y       <= cfg_data;
        pafk_pkg::REG_BASE_HD:  base_heading <= cfg_data[15:0];
        pafk_pkg::REG_LEN_ONE:  link_len[0]  <= cfg_data[15:0];
        pafk_pkg::REG_LEN_TWO:  link_len[1]  <= cfg_data[15:0];
        pafk_pkg::REG_LEN_THR:  link_len[2]  <= cfg_data[15:0];
        pafk_pkg::REG_LEN_FOUR: link_len[3]  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Pipeline advances unless a finished word is held at a stalled output.
  logic en;
  logic [DEPTH-1:0] vld;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end
  assign out_valid = vld[DEPTH-1];

  // Prefix-sum headings, wrapping modulo one turn.
  logic [15:0] head [4];
  always_ff @(posedge clk) begin
    if (en) begin
      head[0] <= base_heading + joint_one_angle;
      head[1] <= base_heading + joint_one_angle + joint_two_angle;
      head[2] <= base_heading + joint_one_angle + joint_two_angle + joint_three_angle;
      head[3] <= base_heading + joint_one_angle + joint_two_angle + joint_three_angle
                 + joint_four_angle;
    end
  end

  logic signed [XW-1:0] cs [4];
  logic signed [XW-1:0] sn [4];
  for (genvar k = 0; k < 4; k++) begin : g_link
    pafk_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
      .clk     (clk),
      .en      (en),
      .heading (head[k]),
      .cos_out (cs[k]),
      .sin_out (sn[k])
    );
  end

  // Length times cosine and sine.
  logic signed [AW-1:0] px [4];
  logic signed [AW-1:0] py [4];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        px[k] <= AW'($signed({1'b0, link_len[k]}) * cs[k]);
        py[k] <= AW'($signed({1'b0, link_len[k]}) * sn[k]);
      end
    end
  end

  // Two add stages build the prefix sums on base<<30.
  logic signed [AW-1:0] bx, by;
  logic signed [AW-1:0] ax1 [4];
  logic signed [AW-1:0] ay1 [4];
  logic signed [AW-1:0] ax2 [4];
  logic signed [AW-1:0] ay2 [4];
  assign bx = AW'(base_x) <<< 30;
  assign by = AW'(base_y) <<< 30;
  always_ff @(posedge clk) begin
    if (en) begin
      ax1[0] <= bx + px[0];
      ay1[0] <= by + py[0];
      ax1[1] <= px[1];
      ay1[1] <= py[1];
      ax1[2] <= px[2];
      ay1[2] <= py[2];
      ax1[3] <= px[2] + px[3];
      ay1[3] <= py[2] + py[3];
      ax2[0] <= ax1[0];
      ay2[0] <= ay1[0];
      ax2[1] <= ax1[0] + ax1[1];
      ay2[1] <= ay1[0] + ay1[1];
      ax2[2] <= ax1[0] + ax1[1] + ax1[2];
      ay2[2] <= ay1[0] + ay1[1] + ay1[2];
      ax2[3] <= ax1[0] + ax1[1] + ax1[3];
      ay2[3] <= ay1[0] + ay1[1] + ay1[3];
    end
  end

  // Round to Q.8 and saturate.
  function automatic logic [PW:0] finish(input logic signed [AW-1:0] acc);
    logic signed [AW-1:0] r;
    logic signed [PW-1:0] v;
    logic c;
    r = (acc + (AW'(1) <<< 29)) >>> 30;
    c = 1'b0;
    v = r[PW-1:0];
    if (r > AW'(pafk_pkg::POS_MAX)) begin
      v = pafk_pkg::POS_MAX;
      c = 1'b1;
    end else if (r < AW'(pafk_pkg::POS_MIN)) begin
      v = pafk_pkg::POS_MIN;
      c = 1'b1;
    end
    return {c, v};
  endfunction

  logic [PW:0] fx [4];
  logic [PW:0] fy [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      fx[k] = finish(ax2[k]);
      fy[k] = finish(ay2[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      end_one_x   <= fx[0][PW-1:0];
      end_one_y   <= fy[0][PW-1:0];
      end_two_x   <= fx[1][PW-1:0];
      end_two_y   <= fy[1][PW-1:0];
      end_three_x <= fx[2][PW-1:0];
      end_three_y <= fy[2][PW-1:0];
      tip_x       <= fx[3][PW-1:0];
      tip_y       <= fy[3][PW-1:0];
      clipped     <= fx[0][PW] | fy[0][PW] | fx[1][PW] | fy[1][PW] |
                     fx[2][PW] | fy[2][PW] | fx[3][PW] | fy[3][PW];
    end
  end

endmodule

// File: hdl/pafk_checker.sv
// Port-level checks on the arm pipeline.
module pafk_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [19:0] tip_x
);

  // Input is stalled only by a held output word.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output back-pressure");

  // A held output word keeps its tip_x value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(tip_x)))
    else $error("held output word changed");

  // No output right after reset.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind planar_arm_forward_kinematics pafk_checker u_pafk_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .tip_x     (tip_x)
);

// File: tb/planar_arm_forward_kinematics_tb.sv
// One expected or observed output word: eight positions and the clip flag.
typedef struct {
  logic signed [19:0] pos [8];
  logic               clip;
} pose_t;

// Scoreboard for arm poses: predicts the link-end positions of each accepted
// word of joint angles and checks the output words in order.
class pose_scoreboard;
  pose_t              pending [$];
  int                 errors;
  logic signed [63:0] bx, by;
  logic [15:0]        heading0;
  logic [63:0]        len [4];

  function void reset_regs();
    bx = 0;
    by = 0;
    heading0 = 0;
    for (int k = 0; k < 4; k++) len[k] = 512;
  endfunction

  function void write_reg(logic [2:0] idx, logic [19:0] val);
    case (idx)
      pafk_pkg::REG_BASE_X: bx = 64'(signed'(val));
      pafk_pkg::REG_BASE_Y: by = 64'(signed'(val));
      pafk_pkg::REG_BASE_HD: heading0 = val[15:0];
      pafk_pkg::REG_LEN_ONE, pafk_pkg::REG_LEN_TWO,
      pafk_pkg::REG_LEN_THR, pafk_pkg::REG_LEN_FOUR:
        len[idx - pafk_pkg::REG_LEN_ONE] = {48'd0, val[15:0]};
      default: ;
    endcase
  endfunction

  // Rotation-mode CORDIC with the half-plane fold.
  function void sincos(logic [15:0] h, output logic signed [63:0] c,
                       output logic signed [63:0] s);
    logic [31:0]        p;
    logic               flip;
    logic signed [63:0] x, y, z, nx;
    p = {h, 16'd0} & (32'hFFFF_FFFF << (32 - pafk_pkg::ANGLE_BITS_DEF));
    flip = 1'b0;
    if ((p + 32'h4000_0000) & 32'h8000_0000) begin
      p = p - 32'h8000_0000;
      flip = 1'b1;
    end
    x = 652032874;
    y = 0;
    z = 64'(signed'(p));
    for (int i = 0; i < pafk_pkg::CORDIC_STAGES_DEF; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - 64'(pafk_pkg::atan_turn(i));
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + 64'(pafk_pkg::atan_turn(i));
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function logic signed [19:0] round_sat(logic signed [63:0] acc, inout logic clip);
    logic signed [63:0] v;
    v = (acc + (64'sd1 <<< 29)) >>> 30;
    if (v > 524287) begin
      v = 524287;
      clip = 1'b1;
    end
    if (v < -524288) begin
      v = -524288;
      clip = 1'b1;
    end
    return v[19:0];
  endfunction

  // Notes an accepted word of joint angles.
  function void note_angles(logic [15:0] a [4]);
    pose_t              r;
    logic [15:0]        h;
    logic signed [63:0] ax, ay, c, s;
    h = heading0;
    ax = bx <<< 30;
    ay = by <<< 30;
    r.clip = 1'b0;
    for (int k = 0; k < 4; k++) begin
      h = h + a[k];
      sincos(h, c, s);
      ax = ax + $signed(len[k]) * c;
      ay = ay + $signed(len[k]) * s;
      r.pos[2*k] = round_sat(ax, r.clip);
      r.pos[2*k+1] = round_sat(ay, r.clip);
    end
    pending = {pending, r};
  endfunction

  // Checks one output word against the oldest expected pose.
  function void check_pose(pose_t got);
    pose_t e;
    bit    bad;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected output word");
      return;
    end
    e = pending.pop_front();
    bad = (got.clip !== e.clip);
    for (int k = 0; k < 8; k++) if (got.pos[k] !== e.pos[k]) bad = 1;
    if (bad) begin
      errors++;
      if (errors <= 10) begin
        $display("mismatch: expected pos %p clip %0b", e.pos, e.clip);
        $display("          actual   pos %p clip %0b", got.pos, got.clip);
      end
    end
  endfunction
endclass

module planar_arm_forward_kinematics_tb;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [2:0]                 cfg_index = '0;
  logic [pafk_pkg::CFG_W-1:0] cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [15:0] j1 = '0, j2 = '0, j3 = '0, j4 = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic signed [19:0] e1x, e1y, e2x, e2y, e3x, e3y, tx, ty;
  logic              clipped;

  pose_scoreboard board;
  bit             hold_off = 1'b0;
  bit             rx_idle = 1'b1;

  planar_arm_forward_kinematics u_top (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
    .joint_one_angle(j1), .joint_two_angle(j2), .joint_three_angle(j3),
    .joint_four_angle(j4), .out_valid(out_valid), .out_stall(out_stall),
    .end_one_x(e1x), .end_one_y(e1y), .end_two_x(e2x), .end_two_y(e2y),
    .end_three_x(e3x), .end_three_y(e3y), .tip_x(tx), .tip_y(ty),
    .clipped(clipped)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [19:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    board.write_reg(idx, val);
  endtask

  // Offers one word of angles and waits until it is accepted.
  task automatic send_angles(logic [15:0] a1, logic [15:0] a2, logic [15:0] a3,
                             logic [15:0] a4, bit gaps);
    logic [15:0] a [4];
    int          g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    j1 <= a1;
    j2 <= a2;
    j3 <= a3;
    j4 <= a4;
    a = '{a1, a2, a3, a4};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_angles(a);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (pafk_pkg::CORDIC_STAGES_DEF + 12) @(negedge clk);
  endtask

  // Angles near the fold points and the wrap, with random ones between.
  function logic [15:0] pick_angle();
    logic [15:0] specials [8] = '{16'h0000, 16'h4000, 16'hC000, 16'h8000,
                                  16'h7FFF, 16'h3FFF, 16'hBFFF, 16'hFFFF};
    if ($urandom_range(0, 3) == 0) return specials[$urandom_range(0, 7)];
    return 16'($urandom());
  endfunction

  // Output side: sample at the rising edge, change stall at the falling one.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      pose_t got;
      got.pos = '{e1x, e1y, e2x, e2y, e3x, e3y, tx, ty};
      got.clip = clipped;
      board.check_pose(got);
    end
  end

  initial begin
    int g;
    bit held;
    held = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off && !held) begin
        out_stall <= 1'b1;
        repeat (200) @(negedge clk);
        held = 1'b1;
      end
      g = rx_idle ? 0 : gap_len();
      out_stall <= (g > 0);
      if (g > 0) repeat (g) @(negedge clk);
      else @(negedge clk);
    end
  end

  initial begin
    #4000000;
    $display("planar_arm_forward_kinematics_tb: done, errors");
    $finish;
  end

  initial begin
    logic [15:0] edge_vals [6] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF,
                                   16'h4000, 16'hC000};
    board = new();
    board.errors = 0;
    board.reset_regs();
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes, quadrant folds and heading wrap.
    foreach (edge_vals[i]) send_angles(edge_vals[i], edge_vals[i], edge_vals[i],
                                       edge_vals[i], 1'b0);
    send_angles(16'h2000, 16'h2000, 16'h2000, 16'h2000, 1'b0);
    send_angles(16'h3FFF, 16'h0001, 16'hBFFF, 16'h4001, 1'b0);
    send_angles(16'hAAAA, 16'h5555, 16'h0F0F, 16'hF0F0, 1'b0);
    drain();

    // Saturation: longest links at the far corner of the workspace.
    write_reg(pafk_pkg::REG_BASE_X, 20'h7FFFF);
    write_reg(pafk_pkg::REG_BASE_Y, 20'h80000);
    write_reg(pafk_pkg::REG_BASE_HD, 20'hFFFFF);
    write_reg(pafk_pkg::REG_LEN_ONE, 20'hFFFF);
    write_reg(pafk_pkg::REG_LEN_TWO, 20'hFFFF);
    write_reg(pafk_pkg::REG_LEN_THR, 20'hFFFF);
    write_reg(pafk_pkg::REG_LEN_FOUR, 20'hFFFF);
    write_reg(3'd7, 20'h12345);
    foreach (edge_vals[i]) send_angles(edge_vals[i], 16'h0000, 16'h0000,
                                       edge_vals[i], 1'b0);
    send_angles(16'h8000, 16'h8000, 16'h0000, 16'h0000, 1'b0);
    drain();

    // Random phases with fresh register settings each time.
    rx_idle = 1'b0;
    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 6) begin
        write_reg(pafk_pkg::REG_BASE_X, 20'h00000);
        write_reg(pafk_pkg::REG_BASE_Y, 20'h00000);
        write_reg(pafk_pkg::REG_LEN_ONE, 20'h0000);
        write_reg(pafk_pkg::REG_LEN_FOUR, 20'h0000);
      end else begin
        write_reg(pafk_pkg::REG_BASE_X, 20'($urandom()));
        write_reg(pafk_pkg::REG_BASE_Y, 20'($urandom()));
        write_reg(pafk_pkg::REG_BASE_HD, 20'($urandom()));
        for (int k = 0; k < 4; k++)
          write_reg(3'(pafk_pkg::REG_LEN_ONE + k), ph[0] ? 20'($urandom()) :
                                                   20'($urandom_range(0, 4096)));
      end
      if (ph == 2) hold_off = 1'b1;
      for (int n = 0; n < 200; n++)
        send_angles(pick_angle(), pick_angle(), pick_angle(), pick_angle(),
                    (ph % 3) != 1);
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0)
      $display("planar_arm_forward_kinematics_tb: done, clean");
    else
      $display("planar_arm_forward_kinematics_tb: done, errors");
    $finish;
  end
endmodule

// File: filelist.f
hdl/pafk_pkg.sv
hdl/pafk_cordic.sv
hdl/planar_arm_forward_kinematics.sv
hdl/pafk_checker.sv
tb/planar_arm_forward_kinematics_tb.sv
